FILE: src/gfh_pkg.sv
`default_nettype none

package gfh_pkg;

   localparam int COUNT_BITS = 32;
   localparam int FIELD_BITS = 128;
   localparam int KEY_BITS_PER_STEP = 8;
   localparam int STEPS = FIELD_BITS / KEY_BITS_PER_STEP;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
   localparam logic [7:0] RED_TOP = 8'hE1;
   localparam int BLOCK_BYTES = 16;

   localparam logic [0:0] REG_KEY_HIGH = 1'b0;
   localparam logic [0:0] REG_KEY_LOW = 1'b1;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  valid_bytes;
      logic        last_block;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_high;
      logic [63:0] digest_low;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic fold;
      logic step;
      logic load_len;
      logic emit;
   } cmd_type;

endpackage

`default_nettype wire

FILE: src/gfh_ctrl.sv
`default_nettype none

module gfh_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output gfh_pkg::cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_FIN   = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [gfh_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        last_ff, last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        at_end;
   logic                        out_free;
   logic                        take;

   assign at_end = (step_ff == gfh_pkg::STEP_LAST);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MUL:  req_ready = at_end && !last_ff;
         default: req_ready = 1'b0;
      endcase
   end

   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      last_in = last_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               last_in = req_last;
               step_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 1'b1;
            if (at_end) begin
               if (last_ff) begin
                  cmd.load_len = 1'b1;
                  state_in = ST_FIN;
               end else if (take) begin
                  cmd.fold = 1'b1;
                  cmd.load = 1'b1;
                  last_in = req_last;
               end else begin
                  cmd.fold = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FIN: begin
            cmd.step = 1'b1;
            step_in = step_ff + 1'b1;
            if (at_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DRAIN) |-> (step_ff == '0))
      else $error("step counter not parked");

   a_no_take_late: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN || state_ff == ST_DRAIN) |-> !req_ready)
      else $error("beat taken during final multiply");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   a_fin_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && at_end) |=> (state_ff == ST_DRAIN))
      else $error("final multiply did not end in drain");

endmodule

`default_nettype wire

FILE: src/gfh_dp.sv
`default_nettype none

module gfh_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gfh_pkg::cmd_type  cmd,
   input  wire gfh_pkg::req_type  req_data,
   input  wire logic [127:0]      key,
   output gfh_pkg::rsp_type       rsp_data
);

   localparam int FB = gfh_pkg::FIELD_BITS;
   localparam int CB = gfh_pkg::COUNT_BITS;
   localparam int KB = gfh_pkg::KEY_BITS_PER_STEP;

   logic [FB-1:0]  acc_ff, acc_in;
   logic [FB-1:0]  z_ff, z_in;
   logic [FB-1:0]  w_ff, w_in;
   logic [FB-1:0]  key_sh_ff, key_sh_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   gfh_pkg::rsp_type rsp_ff, rsp_in;

   logic [FB-1:0]  z_next;
   logic [FB-1:0]  w_next;
   logic [FB-1:0]  blk_mask;
   logic [FB-1:0]  acc_src;
   logic [FB-1:0]  len_word;
   logic [4:0]     vb;
   logic [CB:0]    cnt_sum;

   function automatic logic [2*FB-1:0] gf_step(input logic [FB-1:0] z0,
                                                 input logic [FB-1:0] w0,
                                                 input logic [KB-1:0] kb);
      logic [FB-1:0] z;
      logic [FB-1:0] w;
      logic          carry;
      z = z0;
      w = w0;
      for (int j = 0; j < KB; j++) begin
         if (kb[KB-1-j]) begin
            w = w ^ z;
         end
         carry = z[0];
         z = z >> 1;
         if (carry) begin
            z[FB-1 -: 8] = z[FB-1 -: 8] ^ gfh_pkg::RED_TOP;
         end
      end
      return {z, w};
   endfunction

   assign {z_next, w_next} = gf_step(z_ff, w_ff, key_sh_ff[FB-1 -: KB]);

   assign vb = (req_data.valid_bytes > 5'(gfh_pkg::BLOCK_BYTES))
               ? 5'(gfh_pkg::BLOCK_BYTES) : req_data.valid_bytes;

   always_comb begin
      for (int i = 0; i < gfh_pkg::BLOCK_BYTES; i++) begin
         blk_mask[FB-1-8*i -: 8] = (5'(i) < vb) ? 8'hFF : 8'h00;
      end
   end

   assign acc_src = cmd.fold ? w_next : acc_ff;
   assign cnt_sum = {1'b0, cnt_ff} + (CB+1)'(vb);
   assign len_word = FB'({cnt_ff, 3'b000});

   always_comb begin
      acc_in = acc_ff;
      z_in = z_ff;
      w_in = w_ff;
      key_sh_in = key_sh_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;
      if (cmd.step) begin
         z_in = z_next;
         w_in = w_next;
         key_sh_in = key_sh_ff << KB;
      end
      if (cmd.fold) begin
         acc_in = w_next;
      end
      if (cmd.load) begin
         z_in = acc_src ^ ({req_data.block_high, req_data.block_low} & blk_mask);
         w_in = '0;
         key_sh_in = key;
         cnt_in = cnt_sum[CB] ? {CB{1'b1}} : cnt_sum[CB-1:0];
      end
      if (cmd.load_len) begin
         z_in = w_next ^ len_word;
         w_in = '0;
         key_sh_in = key;
      end
      if (cmd.emit) begin
         rsp_in.digest_high = w_ff[FB-1:64];
         rsp_in.digest_low = w_ff[63:0];
         acc_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
      w_ff <= w_in;
      key_sh_ff <= key_sh_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: src/gf128_polynomial_hash.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | req_data  (block_high, block_low, valid_bytes,
//         |           |                     |            last_block)
// rsp     | out       | rsp_valid/rsp_ready | rsp_data  (digest_high, digest_low)
// csr     | in        | apb write/read      | key_high @ 0x0, key_low @ 0x8
//
// one block is one field multiply: it walks the key 8 bits per cycle
// back-to-back blocks are taken in the last multiply cycle, so blocks follow without a gap
// the last block adds a second multiply for the length, then loads the result register
// reset clears the accumulator, byte count, keys and the result register valid
// a waiting result does not block new beats; only a finished message waits for it

`default_nettype none

module gf128_polynomial_hash (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire gfh_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output gfh_pkg::rsp_type       rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [3:0]        csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [63:0]       key_high_ff, key_high_in;
   logic [63:0]       key_low_ff, key_low_in;
   logic              csr_wr;
   logic [0:0]        csr_reg;
   gfh_pkg::cmd_type  cmd;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg = csr_paddr[3];

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in = key_low_ff;
      if (csr_wr) begin
         case (csr_reg)
            gfh_pkg::REG_KEY_HIGH: key_high_in = csr_pwdata;
            gfh_pkg::REG_KEY_LOW:  key_low_in = csr_pwdata;
            default: key_high_in = key_high_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         gfh_pkg::REG_KEY_HIGH: csr_prdata = key_high_ff;
         gfh_pkg::REG_KEY_LOW:  csr_prdata = key_low_ff;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff <= key_low_in;
      end
   end

   gfh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_block),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   gfh_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .key      ({key_high_ff, key_low_ff}),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
